FILE: rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Calibration register map
    typedef enum logic [2:0] {
        REG_PRESS_SENS   = 3'd0,
        REG_PRESS_OFFSET = 3'd1,
        REG_SENS_TCO     = 3'd2,
        REG_OFFSET_TCO   = 3'd3,
        REG_REF_TEMP     = 3'd4,
        REG_TEMP_COEFF   = 3'd5
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CAL_W       = 16;
    localparam int RAW_W       = 24;
    localparam int TEMP_W      = 19;
    localparam int PRESS_W     = 32;

    // Number of register stages from input to output register
    localparam int PIPE_DEPTH  = 9;

    // 20.00 C reference point, and its distance to -15.00 C
    localparam logic signed [TEMP_W-1:0] TEMP_BASE  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] COLD_DELTA = 19'sd3500;

    // Upper bound of the compensated temperature
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 19'sd133071;

endpackage

FILE: rtl/core/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order temperature and pressure compensation of raw 24-bit
// conversions, using six calibration words.
// ----------------------------------------------------------------------------
// Takes one temperature/pressure conversion pair per beat and returns the
// temperature in 0.01 C and the pressure in Pa. The datapath is a nine-stage
// pipeline (difference, first products, first-order terms, squares,
// second-order terms, final offset/sensitivity, two partial products of the
// 24x40 pressure product, their sum, final subtract and shift into the
// output register). A new pair is accepted every cycle while the pipeline is not
// stalled. When the output beat is not taken the whole pipeline holds, so
// s_ready follows m_ready whenever the output register is full. The
// calibration port is always ready; write it only while no beat is in flight.
// ----------------------------------------------------------------------------
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CAL_W-1:0]              cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [RAW_W-1:0]              s_raw_temp,
    input  logic [RAW_W-1:0]              s_raw_press,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [TEMP_W-1:0]      m_temp_centi,
    output logic signed [PRESS_W-1:0]     m_press_pa
);

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PRESS_SENS:   c1_reg <= cfg_data;
                REG_PRESS_OFFSET: c2_reg <= cfg_data;
                REG_SENS_TCO:     c3_reg <= cfg_data;
                REG_OFFSET_TCO:   c4_reg <= cfg_data;
                REG_REF_TEMP:     c5_reg <= cfg_data;
                REG_TEMP_COEFF:   c6_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: one enable for all stages
    // ------------------------------------------------------------------
    logic                  en;
    logic [PIPE_DEPTH-1:0] v_reg;

    assign en      = m_ready || !v_reg[PIPE_DEPTH-1];
    assign s_ready = en;
    assign m_valid = v_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], s_valid && s_ready};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - C5*256
    // ------------------------------------------------------------------
    logic signed [24:0] dt_s1_reg, dt_s1_next;
    logic [RAW_W-1:0]   d1_s1_reg;

    assign dt_s1_next = $signed({1'b0, s_raw_temp}) - $signed({1'b0, c5_reg, 8'b0});

    // ------------------------------------------------------------------
    // Stage 2: first products
    // ------------------------------------------------------------------
    logic signed [40:0] pt_s2_reg, pt_s2_next;
    logic signed [40:0] po_s2_reg, po_s2_next;
    logic signed [40:0] ps_s2_reg, ps_s2_next;
    logic signed [49:0] pdd_full;
    logic [47:0]        pdd_s2_reg, pdd_s2_next;
    logic [RAW_W-1:0]   d1_s2_reg;

    assign pt_s2_next  = dt_s1_reg * $signed({1'b0, c6_reg});
    assign po_s2_next  = dt_s1_reg * $signed({1'b0, c4_reg});
    assign ps_s2_next  = dt_s1_reg * $signed({1'b0, c3_reg});
    assign pdd_full    = dt_s1_reg * dt_s1_reg;
    assign pdd_s2_next = pdd_full[47:0];

    // ------------------------------------------------------------------
    // Stage 3: first-order terms, temperature, cold flags
    // ------------------------------------------------------------------
    logic signed [17:0]       tshift;
    logic [16:0]              t2;
    logic signed [TEMP_W-1:0] temp_s3_reg, temp_s3_next;
    logic signed [35:0]       off1_s3_reg, off1_s3_next;
    logic signed [35:0]       sens1_s3_reg, sens1_s3_next;
    logic signed [17:0]       low_s3_reg;
    logic signed [18:0]       vlow_s3_reg, vlow_s3_next;
    logic                     cold_s3_reg, cold_s3_next;
    logic                     vcold_s3_reg, vcold_s3_next;
    logic [RAW_W-1:0]         d1_s3_reg;

    always_comb begin
        tshift        = $signed(pt_s2_reg[40:23]);
        t2            = pdd_s2_reg[47:31];
        // TEMP < 20.00 C exactly when the shifted term is negative
        cold_s3_next  = pt_s2_reg[40];
        vlow_s3_next  = 19'(tshift) + COLD_DELTA;
        vcold_s3_next = vlow_s3_next[18];
        temp_s3_next  = TEMP_BASE + 19'(tshift)
                      - (cold_s3_next ? $signed({2'b0, t2}) : 19'sd0);
        off1_s3_next  = $signed({4'b0, c2_reg, 16'b0}) + 36'(po_s2_reg >>> 7);
        sens1_s3_next = $signed({5'b0, c1_reg, 15'b0}) + 36'(ps_s2_reg >>> 8);
    end

    // ------------------------------------------------------------------
    // Stage 4: squares of the distances below 20 C and -15 C
    // ------------------------------------------------------------------
    logic signed [35:0]       sqa_full;
    logic signed [37:0]       sqb_full;
    logic [34:0]              sqa_s4_reg, sqa_s4_next;
    logic [34:0]              sqb_s4_reg, sqb_s4_next;
    logic signed [TEMP_W-1:0] temp_s4_reg;
    logic signed [35:0]       off1_s4_reg, sens1_s4_reg;
    logic                     cold_s4_reg, vcold_s4_reg;
    logic [RAW_W-1:0]         d1_s4_reg;

    assign sqa_full    = low_s3_reg * low_s3_reg;
    assign sqb_full    = vlow_s3_reg * vlow_s3_reg;
    assign sqa_s4_next = sqa_full[34:0];
    assign sqb_s4_next = sqb_full[34:0];

    // ------------------------------------------------------------------
    // Stage 5: second-order corrections (zero when warm)
    // ------------------------------------------------------------------
    logic [37:0]              sq5, sq7, off2_s5_next, sens2_s5_next;
    logic [38:0]              sq11;
    logic [37:0]              off2_s5_reg, sens2_s5_reg;
    logic signed [TEMP_W-1:0] temp_s5_reg;
    logic signed [35:0]       off1_s5_reg, sens1_s5_reg;
    logic [RAW_W-1:0]         d1_s5_reg;

    always_comb begin
        sq5  = {1'b0, sqa_s4_reg, 2'b0} + 38'(sqa_s4_reg);
        sq7  = {sqb_s4_reg[34:0], 3'b0} - 38'(sqb_s4_reg);
        sq11 = {1'b0, sqb_s4_reg, 3'b0} + {3'b0, sqb_s4_reg, 1'b0} + 39'(sqb_s4_reg);
        off2_s5_next  = '0;
        sens2_s5_next = '0;
        if (cold_s4_reg) begin
            off2_s5_next  = {1'b0, sq5[37:1]};
            sens2_s5_next = {2'b0, sq5[37:2]};
            if (vcold_s4_reg) begin
                off2_s5_next  = off2_s5_next + sq7;
                sens2_s5_next = sens2_s5_next + sq11[38:1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: final offset and sensitivity
    // ------------------------------------------------------------------
    logic signed [39:0]       off_s6_reg, off_s6_next;
    logic signed [39:0]       sens_s6_reg, sens_s6_next;
    logic signed [TEMP_W-1:0] temp_s6_reg;
    logic [RAW_W-1:0]         d1_s6_reg;

    assign off_s6_next  = 40'(off1_s5_reg) - $signed({2'b0, off2_s5_reg});
    assign sens_s6_next = 40'(sens1_s5_reg) - $signed({2'b0, sens2_s5_reg});

    // ------------------------------------------------------------------
    // Stage 7: D1*SENS as two partial products
    // ------------------------------------------------------------------
    logic [43:0]              pl_s7_reg, pl_s7_next;
    logic signed [44:0]       ph_s7_reg, ph_s7_next;
    logic signed [39:0]       off_s7_reg;
    logic signed [TEMP_W-1:0] temp_s7_reg;

    assign pl_s7_next = d1_s6_reg * sens_s6_reg[19:0];
    assign ph_s7_next = $signed({1'b0, d1_s6_reg}) * $signed(sens_s6_reg[39:20]);

    // ------------------------------------------------------------------
    // Stage 8: combine partial products
    // ------------------------------------------------------------------
    logic signed [63:0]       prod_s8_reg, prod_s8_next;
    logic signed [39:0]       off_s8_reg;
    logic signed [TEMP_W-1:0] temp_s8_reg;

    assign prod_s8_next = (64'(ph_s7_reg) <<< 20) + $signed({20'b0, pl_s7_reg});

    // ------------------------------------------------------------------
    // Stage 9: P = ((D1*SENS >> 21) - OFF) >> 15 into the output register
    // ------------------------------------------------------------------
    logic signed [44:0]        diff;
    logic signed [PRESS_W-1:0] press_reg, press_next;
    logic signed [TEMP_W-1:0]  temp_out_reg;

    assign diff       = 45'(prod_s8_reg >>> 21) - 45'(off_s8_reg);
    assign press_next = 32'(diff >>> 15);

    assign m_temp_centi = temp_out_reg;
    assign m_press_pa   = press_reg;

    // Datapath registers: advance on the common enable
    always_ff @(posedge aclk) begin
        if (en) begin
            dt_s1_reg    <= dt_s1_next;
            d1_s1_reg    <= s_raw_press;

            pt_s2_reg    <= pt_s2_next;
            po_s2_reg    <= po_s2_next;
            ps_s2_reg    <= ps_s2_next;
            pdd_s2_reg   <= pdd_s2_next;
            d1_s2_reg    <= d1_s1_reg;

            temp_s3_reg  <= temp_s3_next;
            off1_s3_reg  <= off1_s3_next;
            sens1_s3_reg <= sens1_s3_next;
            low_s3_reg   <= tshift;
            vlow_s3_reg  <= vlow_s3_next;
            cold_s3_reg  <= cold_s3_next;
            vcold_s3_reg <= vcold_s3_next;
            d1_s3_reg    <= d1_s2_reg;

            sqa_s4_reg   <= sqa_s4_next;
            sqb_s4_reg   <= sqb_s4_next;
            temp_s4_reg  <= temp_s3_reg;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            cold_s4_reg  <= cold_s3_reg;
            vcold_s4_reg <= vcold_s3_reg;
            d1_s4_reg    <= d1_s3_reg;

            off2_s5_reg  <= off2_s5_next;
            sens2_s5_reg <= sens2_s5_next;
            temp_s5_reg  <= temp_s4_reg;
            off1_s5_reg  <= off1_s4_reg;
            sens1_s5_reg <= sens1_s4_reg;
            d1_s5_reg    <= d1_s4_reg;

            off_s6_reg   <= off_s6_next;
            sens_s6_reg  <= sens_s6_next;
            temp_s6_reg  <= temp_s5_reg;
            d1_s6_reg    <= d1_s5_reg;

            pl_s7_reg    <= pl_s7_next;
            ph_s7_reg    <= ph_s7_next;
            off_s7_reg   <= off_s6_reg;
            temp_s7_reg  <= temp_s6_reg;

            prod_s8_reg  <= prod_s8_next;
            off_s8_reg   <= off_s7_reg;
            temp_s8_reg  <= temp_s7_reg;

            press_reg    <= press_next;
            temp_out_reg <= temp_s8_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0])
        else $error("accepted beat did not enter stage 1");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    a_vcold_in_cold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[2] && vcold_s3_reg |-> cold_s3_reg)
        else $error("below -15 C flag set without below 20 C flag");

    a_warm_no_corr: assert property (@(posedge aclk) disable iff (!aresetn)
        en && v_reg[3] && !cold_s4_reg |=> off2_s5_reg == '0 && sens2_s5_reg == '0)
        else $error("second-order correction applied above 20 C");

    a_temp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_temp_centi <= TEMP_MAX)
        else $error("compensated temperature above its bound");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for baro_sensor_compensation: directed boundary and
// extreme-calibration cases, then random conversion pairs over random
// calibration sets under several sender idle and receiver stall patterns.
// A bit-accurate 64-bit predictor forms the expected temperature and
// pressure for every accepted pair; the result stream is compared in order.
// ----------------------------------------------------------------------------
module testbench;
    import bsc_pkg::*;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  RANDOM_PHASES = 8;
    localparam int  PAIRS_PER_PHASE = 160;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam longint WARM_LIMIT = 2000;
    localparam longint COLD_LIMIT = -1500;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

    typedef struct {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [PRESS_W-1:0] press;
    } reading_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CAL_W-1:0]       cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [RAW_W-1:0]       s_raw_temp = '0;
    logic [RAW_W-1:0]       s_raw_press = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [TEMP_W-1:0]  m_temp_centi;
    logic signed [PRESS_W-1:0] m_press_pa;

    // calibration words as the block should hold them
    logic [CAL_W-1:0] cal_press_sens = '0;
    logic [CAL_W-1:0] cal_press_off  = '0;
    logic [CAL_W-1:0] cal_sens_tco   = '0;
    logic [CAL_W-1:0] cal_off_tco    = '0;
    logic [CAL_W-1:0] cal_ref_temp   = '0;
    logic [CAL_W-1:0] cal_temp_coeff = '0;

    reading_t expected_readings[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int pairs_sent = 0;
    int readings_checked = 0;
    int cal_settings = 1;
    int mismatches = 0;
    int cycle_count = 0;

    baro_sensor_compensation DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_temp   (s_raw_temp),
        .s_raw_press  (s_raw_press),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_temp_centi (m_temp_centi),
        .m_press_pa   (m_press_pa)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d readings outstanding", $time,
                     expected_readings.size());
            $display("baro_sensor_compensation verification failed");
            $finish;
        end
    end

    function automatic reading_t compensate(input logic [RAW_W-1:0] raw_temp,
                                            input logic [RAW_W-1:0] raw_press);
        longint c1, c2, c3, c4, c5, c6;
        longint d1, d2, dt, temp, off, sens, t2, below, sq, off2, sens2, cold;
        longint p;
        reading_t r;
        c1 = {48'd0, cal_press_sens};
        c2 = {48'd0, cal_press_off};
        c3 = {48'd0, cal_sens_tco};
        c4 = {48'd0, cal_off_tco};
        c5 = {48'd0, cal_ref_temp};
        c6 = {48'd0, cal_temp_coeff};
        d2 = {40'd0, raw_temp};
        d1 = {40'd0, raw_press};
        dt   = d2 - (c5 <<< 8);
        temp = WARM_LIMIT + ((dt * c6) >>> 23);
        off  = (c2 <<< 16) + ((dt * c4) >>> 7);
        sens = (c1 <<< 15) + ((dt * c3) >>> 8);
        if (temp < WARM_LIMIT) begin
            t2    = (dt * dt) >>> 31;
            below = temp - WARM_LIMIT;
            sq    = 5 * below * below;
            off2  = sq >>> 1;
            sens2 = sq >>> 2;
            if (temp < COLD_LIMIT) begin
                cold  = (temp - COLD_LIMIT) * (temp - COLD_LIMIT);
                off2  = off2 + 7 * cold;
                sens2 = sens2 + ((11 * cold) >>> 1);
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
        end
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        r.temp  = temp[TEMP_W-1:0];
        r.press = p[PRESS_W-1:0];
        return r;
    endfunction

    // compare every beat taken on the result side with the oldest prediction
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected reading temp=%0d press=%0d", $time,
                         m_temp_centi, m_press_pa);
            end else begin
                want = expected_readings.pop_front();
                readings_checked++;
                if (m_temp_centi !== want.temp) begin
                    mismatches++;
                    $display("%0t: temp_centi expected %0d actual %0d", $time,
                             want.temp, m_temp_centi);
                end
                if (m_press_pa !== want.press) begin
                    mismatches++;
                    $display("%0t: press_pa expected %0d actual %0d", $time,
                             want.press, m_press_pa);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_pair(input logic [RAW_W-1:0] raw_temp,
                             input logic [RAW_W-1:0] raw_press);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_raw_temp  <= raw_temp;
        s_raw_press <= raw_press;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_readings.push_back(compensate(raw_temp, raw_press));
        pairs_sent++;
    endtask

    // drop valid, let every reading come back, then allow the pipe to empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_cal(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            REG_PRESS_SENS:   cal_press_sens = data;
            REG_PRESS_OFFSET: cal_press_off  = data;
            REG_SENS_TCO:     cal_sens_tco   = data;
            REG_OFFSET_TCO:   cal_off_tco    = data;
            REG_REF_TEMP:     cal_ref_temp   = data;
            REG_TEMP_COEFF:   cal_temp_coeff = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_cal(input logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6);
        wait_idle();
        write_cal(REG_PRESS_SENS, c1);
        write_cal(REG_PRESS_OFFSET, c2);
        write_cal(REG_SENS_TCO, c3);
        write_cal(REG_OFFSET_TCO, c4);
        write_cal(REG_REF_TEMP, c5);
        write_cal(REG_TEMP_COEFF, c6);
        cal_settings++;
    endtask

    function automatic logic [CAL_W-1:0] random_cal_word();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return '0;
        if (roll == 1) return CAL_MAX;
        return CAL_W'($urandom);
    endfunction

    // raw temperature within about +-2M counts of the reference point
    function automatic logic [RAW_W-1:0] near_reference_temp();
        int t;
        t = int'(cal_ref_temp) * 256 + int'($urandom_range(0, 1 << 22)) - (1 << 21);
        if (t < 0) t = 0;
        if (t > int'(RAW_MAX)) t = int'(RAW_MAX);
        return t[RAW_W-1:0];
    endfunction

    task automatic test_uncalibrated();
        send_pair('0, '0);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, '0);
        send_pair('0, RAW_MAX);
    endtask

    task automatic test_typical_point();
        load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_pair(24'd8569150, 24'd9085466);
        send_pair(24'd7000000, 24'd9085466);
        send_pair(24'd1000000, 24'd4000000);
    endtask

    // temp_coeff of 2^15 makes the first-order step dT/256, so the reference
    // word places the result right on the 20.00 C and -15.00 C thresholds
    task automatic test_threshold_edges();
        load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd1, 16'd32768);
        send_pair(24'd255, 24'd9085466);
        send_pair(24'd256, 24'd9085466);
        wait_idle();
        write_cal(REG_REF_TEMP, 16'd3500);
        send_pair('0, 24'd9085466);
        wait_idle();
        write_cal(REG_REF_TEMP, 16'd3501);
        send_pair('0, 24'd9085466);
    endtask

    task automatic test_extreme_calibration();
        load_cal(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
        send_pair('0, '0);
        send_pair('0, RAW_MAX);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, '0);
        wait_idle();
        // unmapped indexes must leave the calibration alone
        write_cal(REG_UNMAPPED_LO, '0);
        write_cal(REG_UNMAPPED_HI, '0);
        send_pair(24'h800000, 24'h7FFFFF);
    endtask

    task automatic test_random_traffic();
        logic [RAW_W-1:0] raw_temp;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_cal(random_cal_word(), random_cal_word(), random_cal_word(),
                     random_cal_word(), random_cal_word(), random_cal_word());
            if ($urandom_range(0, 1) == 1) begin
                write_cal($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                          CAL_W'($urandom));
            end
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
                if (phase == 2 && n == PAIRS_PER_PHASE / 2) begin
                    // hold the sender until the pipeline has emptied
                    s_valid <= 1'b0;
                    while (expected_readings.size() != 0) @(posedge aclk);
                end
                raw_temp = ($urandom_range(0, 2) == 0) ? near_reference_temp()
                                                        : RAW_W'($urandom);
                send_pair(raw_temp, RAW_W'($urandom));
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_uncalibrated();
        test_typical_point();
        test_threshold_edges();
        test_extreme_calibration();
        test_random_traffic();
        wait_idle();
        $display("Checked %0d readings from %0d conversion pairs", readings_checked,
                 pairs_sent);
        $display("over %0d calibration sets, thresholds and idle/stall mixes",
                 cal_settings);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("baro_sensor_compensation verification clean");
        end else begin
            $display("baro_sensor_compensation verification failed");
        end
        $finish;
    end

endmodule
